FILE: hw/rtl/pdvd_pkg.sv
// Shared types and constants for the postings delta vint decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdvd_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    CmdByte   = 2'd0,
    CmdStart  = 2'd1,
    CmdSkip   = 2'd2,
    CmdBitmap = 2'd3
  } cmd_e;

  // Result kinds carried on the output tuser.
  localparam logic KindPosting = 1'b0;
  localparam logic KindEnd     = 1'b1;

  // Stream widths.
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 64;

  // Word address of a doc number (doc >> 5) and the bitmap write index.
  localparam int unsigned DocWordW  = 27;
  localparam int unsigned BmIndexW  = 11;

  // Output queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef struct packed {
    logic        kind;
    logic [31:0] doc_id;
    logic [31:0] term_freq;
    logic        last;
  } result_t;

  // Requests from the decoder to the bitmap store.
  typedef struct packed {
    logic                wr_en;
    logic [BmIndexW-1:0] wr_index;
    logic [31:0]         wr_data;
    logic                rd_en;
    logic [DocWordW-1:0] rd_word;
  } bm_req_t;

  // Responses from the bitmap store; read data arrive in the cycle after a read.
  typedef struct packed {
    logic        busy;
    logic        in_range;
    logic [31:0] rd_data;
  } bm_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pdvd_bitmap.sv
// Deleted-doc bitmap: one synchronous memory with a registered read and a
// clearing sweep after reset. Depends on pdvd_pkg.
`default_nettype none

module pdvd_bitmap import pdvd_pkg::*; #(
  parameter int unsigned BITMAP_WORDS = 2048
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  bm_req_t req_i,
  output bm_rsp_t rsp_o
);

  localparam int unsigned AddrW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [DocWordW-1:0] WordsLimit = DocWordW'(BITMAP_WORDS);
  localparam logic [AddrW-1:0]    LastAddr   = AddrW'(BITMAP_WORDS - 1);

  logic [31:0] mem_q [BITMAP_WORDS];

  logic             clr_q;
  logic             clr_d;
  logic [AddrW-1:0] clr_addr_q;
  logic [AddrW-1:0] clr_addr_d;

  logic [DocWordW-1:0] wr_word;
  logic                wr_ok;
  logic [AddrW-1:0]    wr_addr;
  logic                rd_ok;
  logic [AddrW-1:0]    rd_addr;
  logic                in_range_q;
  logic [31:0]         rd_data_q;

  // Address decode and range checks for both ports.
  assign wr_word = {{(DocWordW - BmIndexW){1'b0}}, req_i.wr_index};
  assign wr_ok   = wr_word < WordsLimit;
  assign wr_addr = wr_word[AddrW-1:0];
  assign rd_ok   = req_i.rd_word < WordsLimit;
  assign rd_addr = req_i.rd_word[AddrW-1:0];

  // Clearing sweep: one word per cycle from address zero after reset.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port, shared by the sweep and bitmap word writes.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.wr_en && wr_ok) begin
      mem_q[wr_addr] <= req_i.wr_data;
    end
  end

  // Read port with registered data; a word beyond the store reads as live.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      in_range_q <= rd_ok;
      if (rd_ok) begin
        rd_data_q <= mem_q[rd_addr];
      end
    end
  end

  assign rsp_o.busy     = clr_q;
  assign rsp_o.in_range = in_range_q;
  assign rsp_o.rd_data  = rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pdvd_out_fifo.sv
// Small output queue of decoded results that decouples the stream sides.
// Depends on pdvd_pkg.
`default_nettype none

module pdvd_out_fifo import pdvd_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  result_t             push_data_i,
  input  wire                 pop_i,
  output result_t             head_o,
  output logic                valid_o,
  output logic [FifoCntW-1:0] count_o
);

  result_t              entries_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q;
  logic [FifoPtrW-1:0]  rd_ptr_q;
  logic [FifoCntW-1:0]  count_q;
  logic [FifoCntW-1:0]  count_d;

  // Entry storage; the write pointer never reaches a live entry.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + FifoCntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  assign head_o  = entries_q[rd_ptr_q];
  assign valid_o = count_q != '0;
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/postings_delta_vint_decoder.sv
// Top level of the postings delta vint decoder: request decode, vint and doc
// accumulators, bitmap lookup stage. Depends on pdvd_pkg, pdvd_bitmap, pdvd_out_fifo.
//
//   Channel   Dir   tuser          tlast   tdata
//   s_axis    in    cmd (2 bits)   -       request fields, 120 bits
//   m_axis    out   kind (1 bit)   last    doc_id, term_freq, 64 bits
//
// One request is taken per cycle while s_axis_tready is high. A completed
// posting reads the bitmap memory in the cycle of its final byte; the lookup
// stage registers it, it enters the output queue in the following cycle and
// then shows at m_axis. After reset the bitmap is swept to zero, during
// which s_axis_tready stays low. The four-entry output queue holds results
// while m_axis stalls; s_axis_tready drops once it could no longer take more.
`default_nettype none

module postings_delta_vint_decoder import pdvd_pkg::*; #(
  parameter int unsigned BITMAP_WORDS = 2048
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Lowest bit up: data_byte[7:0], doc_count[38:8], target_doc[70:39],
  // bitmap_index[81:71], bitmap_word[113:82], zero fill[119:114].
  input  wire  [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  wire  [1:0]          s_axis_tuser,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // Lowest bit up: doc_id[31:0], term_freq[63:32].
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready
);

  localparam logic [2:0] VintMaxGroups = 3'd5;

  // Request fields.
  cmd_e         cmd;
  logic [7:0]   data_byte;
  logic [30:0]  doc_count;
  logic [31:0]  target_doc;
  logic [10:0]  bitmap_index;
  logic [31:0]  bitmap_word;

  assign cmd          = cmd_e'(s_axis_tuser);
  assign data_byte    = s_axis_tdata[7:0];
  assign doc_count    = s_axis_tdata[38:8];
  assign target_doc   = s_axis_tdata[70:39];
  assign bitmap_index = s_axis_tdata[81:71];
  assign bitmap_word  = s_axis_tdata[113:82];

  // Decoder state.
  logic [31:0] doc_accum_q, doc_accum_d;
  logic [31:0] freq_value_q, freq_value_d;
  logic [30:0] postings_left_q, postings_left_d;
  logic [31:0] vint_accum_q, vint_accum_d;
  logic [2:0]  vint_shift_q, vint_shift_d;
  logic        expect_freq_q, expect_freq_d;
  logic [31:0] skip_target_q, skip_target_d;

  // Lookup stage registers.
  logic        p1_valid_q, p1_valid_d;
  logic [31:0] p1_doc_q, p1_doc_d;
  logic [31:0] p1_freq_q, p1_freq_d;
  logic        p1_last_q, p1_last_d;
  logic        p1_skip_q, p1_skip_d;

  logic        accept;
  logic [31:0] group_bits;
  logic [31:0] vint_value;
  logic [31:0] doc_sum;
  logic        finish;
  logic [31:0] fin_doc;

  bm_req_t bm_req;
  bm_rsp_t bm_rsp;

  logic                deleted;
  logic                dropped;
  logic                emit;
  result_t             emit_data;
  result_t             head;
  logic                fifo_valid;
  logic [FifoCntW-1:0] fifo_count;
  logic [FifoCntW-1:0] pending;

  // Room check counts both the queue and the result still in the lookup stage.
  assign pending       = fifo_count + FifoCntW'(p1_valid_q);
  assign s_axis_tready = !bm_rsp.busy && (pending < FifoCntW'(FifoDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Place the 7-bit group of this byte; groups at or past bit 32 drop out.
  always_comb begin
    case (vint_shift_q)
      3'd0:    group_bits = {25'd0, data_byte[6:0]};
      3'd1:    group_bits = {18'd0, data_byte[6:0], 7'd0};
      3'd2:    group_bits = {11'd0, data_byte[6:0], 14'd0};
      3'd3:    group_bits = {4'd0, data_byte[6:0], 21'd0};
      3'd4:    group_bits = {data_byte[3:0], 28'd0};
      default: group_bits = '0;
    endcase
  end

  assign vint_value = vint_accum_q | group_bits;
  assign doc_sum    = doc_accum_q + {1'b0, vint_value[31:1]};

  // Request decode and accumulator update.
  always_comb begin
    doc_accum_d     = doc_accum_q;
    freq_value_d    = freq_value_q;
    postings_left_d = postings_left_q;
    vint_accum_d    = vint_accum_q;
    vint_shift_d    = vint_shift_q;
    expect_freq_d   = expect_freq_q;
    skip_target_d   = skip_target_q;
    finish          = 1'b0;
    fin_doc         = doc_accum_q;
    bm_req.wr_en    = 1'b0;
    bm_req.wr_index = bitmap_index;
    bm_req.wr_data  = bitmap_word;
    if (accept) begin
      case (cmd)
        CmdByte: begin
          if (postings_left_q != '0) begin
            if (data_byte[7]) begin
              vint_accum_d = vint_value;
              if (vint_shift_q < VintMaxGroups) begin
                vint_shift_d = vint_shift_q + 3'd1;
              end
            end else begin
              vint_accum_d = '0;
              vint_shift_d = '0;
              if (expect_freq_q) begin
                // Second integer of a posting: the frequency.
                expect_freq_d = 1'b0;
                freq_value_d  = vint_value;
                finish        = 1'b1;
              end else begin
                doc_accum_d = doc_sum;
                fin_doc     = doc_sum;
                if (vint_value[0]) begin
                  freq_value_d = 32'd1;
                  finish       = 1'b1;
                end else begin
                  expect_freq_d = 1'b1;
                end
              end
            end
          end
        end
        CmdStart: begin
          postings_left_d = doc_count;
          doc_accum_d     = '0;
          vint_accum_d    = '0;
          vint_shift_d    = '0;
          expect_freq_d   = 1'b0;
        end
        CmdSkip: begin
          skip_target_d = target_doc;
        end
        CmdBitmap: begin
          bm_req.wr_en = 1'b1;
        end
        default: begin
          bm_req.wr_en = 1'b0;
        end
      endcase
    end
    if (finish) begin
      postings_left_d = postings_left_q - 31'd1;
    end
    // A finished posting reads its bitmap word.
    bm_req.rd_en   = finish;
    bm_req.rd_word = fin_doc[31:5];
  end

  // A finished posting moves to the lookup stage.
  assign p1_valid_d = finish;
  assign p1_doc_d   = fin_doc;
  assign p1_freq_d  = freq_value_d;
  assign p1_last_d  = postings_left_d == '0;
  assign p1_skip_d  = fin_doc < skip_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_accum_q     <= '0;
      freq_value_q    <= '0;
      postings_left_q <= '0;
      vint_accum_q    <= '0;
      vint_shift_q    <= '0;
      expect_freq_q   <= 1'b0;
      skip_target_q   <= '0;
      p1_valid_q      <= 1'b0;
    end else begin
      doc_accum_q     <= doc_accum_d;
      freq_value_q    <= freq_value_d;
      postings_left_q <= postings_left_d;
      vint_accum_q    <= vint_accum_d;
      vint_shift_q    <= vint_shift_d;
      expect_freq_q   <= expect_freq_d;
      skip_target_q   <= skip_target_d;
      p1_valid_q      <= p1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      p1_doc_q  <= p1_doc_d;
      p1_freq_q <= p1_freq_d;
      p1_last_q <= p1_last_d;
      p1_skip_q <= p1_skip_d;
    end
  end

  pdvd_bitmap #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_bitmap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (bm_req),
    .rsp_o (bm_rsp)
  );

  // Lookup stage: drop deleted or skipped docs, keep an end marker on the last.
  assign deleted = bm_rsp.in_range && bm_rsp.rd_data[p1_doc_q[4:0]];
  assign dropped = deleted || p1_skip_q;
  assign emit    = p1_valid_q && (!dropped || p1_last_q);

  always_comb begin
    emit_data.kind      = dropped ? KindEnd : KindPosting;
    emit_data.doc_id    = dropped ? 32'd0 : p1_doc_q;
    emit_data.term_freq = dropped ? 32'd0 : p1_freq_q;
    emit_data.last      = p1_last_q;
  end

  pdvd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .push_data_i(emit_data),
    .pop_i      (fifo_valid && m_axis_tready),
    .head_o     (head),
    .valid_o    (fifo_valid),
    .count_o    (fifo_count)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = {head.term_freq, head.doc_id};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

FILE: test/postings_delta_vint_decoder_tb.sv
// Self-checking testbench for postings_delta_vint_decoder: a directed table, then random
// postings lists with random sender gaps and receiver stalls. Depends on pdvd_pkg and the RTL.
`default_nettype none

module postings_delta_vint_decoder_tb import pdvd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BmWords     = 2048;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned DirRows     = 25;
  localparam int unsigned DrainCycles = 20;
  localparam result_t     NoResult    = '0;

  // Request fields, declared from the highest bit down to match the tdata layout.
  typedef struct packed {
    logic [31:0] bm_word;
    logic [10:0] bm_index;
    logic [31:0] target_doc;
    logic [30:0] doc_count;
    logic [7:0]  data_byte;
  } in_fields_t;

  // One directed request: a is the byte, count, target or index; b is the bitmap word.
  typedef struct {
    cmd_e        c;
    logic [31:0] a;
    logic [31:0] b;
    bit          fixed;
    result_t     res;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  // Expected postings, oldest first, and the error tally.
  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;

  // Sender pacing state.
  int unsigned burst_left = 0;
  bit          tx_active  = 1'b0;

  // Receiver stall pattern state.
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_tick      = 0;

  // Decoder state as the testbench predicts it.
  logic [31:0] pr_doc       = '0;
  logic [31:0] pr_freq      = '0;
  logic [30:0] pr_left      = '0;
  logic [31:0] pr_vacc      = '0;
  int unsigned pr_vshift    = 0;
  bit          pr_want_freq = 1'b0;
  logic [31:0] pr_skip      = '0;
  logic [31:0] pr_deleted [BmWords] = '{default: '0};

  dir_row_t dir_rows [DirRows];

  postings_delta_vint_decoder #(
    .BITMAP_WORDS(BmWords)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A posting is complete: count it down and decide whether it shows.
  task automatic close_posting(output bit has, output result_t r);
    logic [26:0] word_ix;
    bit          dropped;
    pr_left = pr_left - 31'd1;
    word_ix = pr_doc[31:5];
    dropped = (pr_doc < pr_skip);
    if (word_ix < BmWords && pr_deleted[word_ix[10:0]][pr_doc[4:0]]) begin
      dropped = 1'b1;
    end
    has = 1'b0;
    r   = NoResult;
    if (!dropped) begin
      has = 1'b1;
      r   = '{KindPosting, pr_doc, pr_freq, (pr_left == '0)};
    end else if (pr_left == '0) begin
      has = 1'b1;
      r   = '{KindEnd, 32'd0, 32'd0, 1'b1};
    end
  endtask

  // Predict the effect of one accepted request.
  task automatic decode_request(input cmd_e c, input in_fields_t f,
                                output bit has, output result_t r);
    logic [31:0] value;
    int unsigned amount;
    has = 1'b0;
    r   = NoResult;
    case (c)
      CmdByte: begin
        if (pr_left != '0) begin
          amount = 7 * pr_vshift;
          // Groups that land at or above bit 32 are lost.
          if (amount < 32) begin
            pr_vacc = pr_vacc | ({25'd0, f.data_byte[6:0]} << amount);
          end
          if (f.data_byte[7]) begin
            if (pr_vshift < 5) pr_vshift++;
          end else begin
            value     = pr_vacc;
            pr_vacc   = '0;
            pr_vshift = 0;
            if (pr_want_freq) begin
              pr_want_freq = 1'b0;
              pr_freq      = value;
              close_posting(has, r);
            end else begin
              pr_doc = pr_doc + (value >> 1);
              if (value[0]) begin
                pr_freq = 32'd1;
                close_posting(has, r);
              end else begin
                pr_want_freq = 1'b1;
              end
            end
          end
        end
      end
      CmdStart: begin
        pr_left      = f.doc_count;
        pr_doc       = '0;
        pr_vacc      = '0;
        pr_vshift    = 0;
        pr_want_freq = 1'b0;
      end
      CmdSkip: begin
        pr_skip = f.target_doc;
      end
      default: begin
        if (f.bm_index < BmWords) pr_deleted[f.bm_index] = f.bm_word;
      end
    endcase
  endtask

  function automatic in_fields_t rand_fields();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    return v[113:0];
  endfunction

  // Overwrite the field that the command uses.
  function automatic in_fields_t place(cmd_e c, in_fields_t base, logic [31:0] a,
                                       logic [31:0] b);
    in_fields_t f;
    f = base;
    case (c)
      CmdByte:  f.data_byte  = a[7:0];
      CmdStart: f.doc_count  = a[30:0];
      CmdSkip:  f.target_doc = a;
      default: begin
        f.bm_index = a[10:0];
        f.bm_word  = b;
      end
    endcase
    return f;
  endfunction

  task automatic lower_valid();
    if (tx_active) begin
      s_axis_tvalid <= 1'b0;
      tx_active = 1'b0;
    end
  endtask

  // Bursts of back-to-back requests separated by random gaps.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      lower_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end
  endtask

  // Offer one request, wait for the handshake, then record what it should produce.
  task automatic send_req(input cmd_e c, input in_fields_t f, input bit fixed_en,
                          input result_t fixed_r);
    bit      has;
    result_t r;
    bit      counts;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {6'd0, f};
    s_axis_tvalid <= 1'b1;
    tx_active = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    counts = !(c == CmdByte && pr_left == '0);
    decode_request(c, f, has, r);
    if (fixed_en) begin
      pending_results.push_back(fixed_r);
    end else if (has) begin
      pending_results.push_back(r);
    end
    if (counts) items_sent++;
    pace_sender();
  endtask

  task automatic send_cmd(input cmd_e c, input logic [31:0] a, input logic [31:0] b);
    send_req(c, place(c, rand_fields(), a, b), 1'b0, NoResult);
  endtask

  // Encode a value as a vint, now and then padded with empty groups.
  task automatic send_vint(input logic [31:0] value);
    logic [31:0] v;
    logic [6:0]  grp;
    int unsigned pad;
    v   = value;
    pad = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
    forever begin
      grp = v[6:0];
      v   = v >> 7;
      if (v == '0) break;
      send_cmd(CmdByte, {24'd0, 1'b1, grp}, '0);
    end
    if (pad == 0) begin
      send_cmd(CmdByte, {24'd0, 1'b0, grp}, '0);
    end else begin
      send_cmd(CmdByte, {24'd0, 1'b1, grp}, '0);
      repeat (pad - 1) send_cmd(CmdByte, 32'h80, '0);
      send_cmd(CmdByte, 32'h00, '0);
    end
  endtask

  // Any command with fully random fields.
  task automatic send_noise();
    cmd_e c;
    c = cmd_e'($urandom_range(0, 3));
    send_req(c, rand_fields(), 1'b0, NoResult);
  endtask

  // One postings list, with a skip target and bitmap words sometimes set up beforehand.
  task automatic run_list();
    int unsigned n;
    int unsigned pick;
    int unsigned delta;
    logic [31:0] fq;
    bit          f1;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_cmd(CmdSkip, 32'd0, '0);
    end else if (pick < 45) begin
      send_cmd(CmdSkip, $urandom_range(0, 3000), '0);
    end else if (pick < 50) begin
      send_cmd(CmdSkip, $urandom, '0);
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_cmd(CmdBitmap, $urandom_range(0, 15), $urandom & $urandom & $urandom);
      end
    end
    if ($urandom_range(0, 19) == 0) send_cmd(CmdBitmap, $urandom_range(0, 2047), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) n = 0;
    else if (pick < 85) n = $urandom_range(1, 8);
    else n = $urandom_range(9, 30);
    send_cmd(CmdStart, n, '0);
    for (int unsigned i = 0; i < n; i++) begin
      // Now and then the list is abandoned or disturbed.
      if ($urandom_range(0, 49) == 0) break;
      if ($urandom_range(0, 29) == 0) send_noise();
      pick = $urandom_range(0, 99);
      if (pick < 85) delta = $urandom_range(0, 100);
      else if (pick < 95) delta = $urandom_range(0, 70000);
      else delta = $urandom >> 1;
      f1 = 1'($urandom_range(0, 1));
      send_vint({delta[30:0], f1});
      if (!f1) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) fq = $urandom_range(0, 20);
        else if (pick < 9) fq = $urandom_range(0, 1000);
        else fq = $urandom;
        send_vint(fq);
      end
    end
  endtask

  // Hold the sender idle until every result has come.
  task automatic wait_results_drained();
    lower_valid();
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Receiver: the stall pattern switches at random among four modes.
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(5, 40);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
      default: m_axis_tready <= (rx_tick[1:0] != 2'b11);
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast};
      if (pending_results.size() == 0) begin
        note_error($sformatf("result with nothing pending: kind %0d doc %h freq %h last %0d",
                             got.kind, got.doc_id, got.term_freq, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          note_error($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
        end
        if (got.doc_id !== want.doc_id) begin
          note_error($sformatf("doc_id: expected %h, got %h", want.doc_id, got.doc_id));
        end
        if (got.term_freq !== want.term_freq) begin
          note_error($sformatf("term_freq: expected %h, got %h", want.term_freq,
                               got.term_freq));
        end
        if (got.last !== want.last) begin
          note_error($sformatf("last: expected %0d, got %0d", want.last, got.last));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random lists, drain.
  initial begin
    bit mid_drained;
    mid_drained = 1'b0;
    dir_rows = '{
      // A byte before any list is ignored.
      '{CmdByte,   32'h81,       32'h0, 1'b0, NoResult},
      '{CmdStart,  32'd3,        32'h0, 1'b0, NoResult},
      // Doc code 3: doc 1 with an implied freq of 1.
      '{CmdByte,   32'h03,       32'h0, 1'b1, '{KindPosting, 32'd1, 32'd1, 1'b0}},
      // Doc code 4: doc 3, the freq follows as an overlong vint.
      '{CmdByte,   32'h04,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'h7F,       32'h0, 1'b1, '{KindPosting, 32'd3, 32'hFFFFFFFF, 1'b0}},
      // Delete doc 5, then make doc 5 the last posting: end-only result.
      '{CmdBitmap, 32'd0,        32'h20, 1'b0, NoResult},
      '{CmdByte,   32'h05,       32'h0, 1'b1, '{KindEnd, 32'd0, 32'd0, 1'b1}},
      '{CmdByte,   32'h00,       32'h0, 1'b0, NoResult},
      // Absent term: nothing comes out and bytes are ignored.
      '{CmdStart,  32'd0,        32'h0, 1'b0, NoResult},
      '{CmdByte,   32'h01,       32'h0, 1'b0, NoResult},
      // Largest skip target and count; the widest doc code is dropped silently.
      '{CmdSkip,   32'hFFFFFFFF, 32'h0, 1'b0, NoResult},
      '{CmdStart,  32'h7FFFFFFF, 32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'hFF,       32'h0, 1'b0, NoResult},
      '{CmdByte,   32'h0F,       32'h0, 1'b0, NoResult},
      '{CmdSkip,   32'd0,        32'h0, 1'b0, NoResult},
      '{CmdBitmap, 32'd2047,     32'hFFFFFFFF, 1'b0, NoResult},
      // Doc 0x80000000 lies beyond the bitmap and stays live.
      '{CmdByte,   32'h03,       32'h0, 1'b0, NoResult}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_req(dir_rows[i].c, place(dir_rows[i].c, '0, dir_rows[i].a, dir_rows[i].b),
               dir_rows[i].fixed, dir_rows[i].res);
    end
    wait_results_drained();

    while (items_sent < DirRows + RandomItems) begin
      if (!mid_drained && items_sent > DirRows + RandomItems / 2) begin
        mid_drained = 1'b1;
        wait_results_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_list();
      end
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
